/* sv/cles_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the character LCD expander sequencer.
// Used by every module of the block; depends on nothing.
package cles_pkg;

  localparam int NUMBER_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int POW_W = 32;

  localparam logic [7:0] ADDR_RESET  = 8'd78;
  localparam logic [7:0] IMAGE_RESET = 8'h08;
  localparam logic [7:0] BIT_RS      = 8'h01;
  localparam logic [7:0] BIT_E       = 8'h04;
  localparam logic [7:0] BIT_BL      = 8'h08;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;

  localparam logic [1:0] ACT_CMD  = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_NUM  = 2'd2;
  localparam logic [1:0] ACT_NIB  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         byte_value;
    logic [7:0]         position;
    logic signed [15:0] number;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bus_address;
    logic [7:0] port_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_CMD,
    OP_DATA,
    OP_NIB
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
    logic       last;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Number of decimal digits needed for the largest magnitude of a bits-wide value.
  function automatic int digits_for(input int bits);
    longint lim;
    longint p;
    int     d;
    lim = longint'(1) << (bits - 1);
    p = 1;
    d = 0;
    for (int i = 0; i < 11; i++) begin
      if (p <= lim) begin
        p = p * 10;
        d = d + 1;
      end
    end
    return d;
  endfunction

  function automatic logic [POW_W-1:0] pow10(input logic [3:0] k);
    logic [POW_W-1:0] p;
    case (k)
      4'd0: p = 32'd1;
      4'd1: p = 32'd10;
      4'd2: p = 32'd100;
      4'd3: p = 32'd1000;
      4'd4: p = 32'd10000;
      4'd5: p = 32'd100000;
      4'd6: p = 32'd1000000;
      4'd7: p = 32'd10000000;
      4'd8: p = 32'd100000000;
      4'd9: p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

/* sv/cles_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input items and turns them into byte and nibble operations.
// Numbers are converted to decimal digits by repeated subtraction. Depends on cles_pkg.
module cles_front
  import cles_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  output logic     push,
  output op_t      push_op,
  input  q_stat_t  q_stat,
  output logic     idle
);

  localparam int DIGITS = digits_for(NUMBER_BITS);
  localparam int KW = $clog2(DIGITS);

  typedef enum logic [1:0] {
    F_IDLE,
    F_POS,
    F_SIGN,
    F_DIGIT
  } fstate_t;

  fstate_t                state, state_next;
  logic [7:0]             pos, pos_next;
  logic                   neg, neg_next;
  logic [NUMBER_BITS-1:0] mag, mag_next;
  logic [KW-1:0]          k, k_next;
  logic [3:0]             cnt, cnt_next;
  logic                   started, started_next;

  logic signed [NUMBER_BITS-1:0] num_ext;
  logic [NUMBER_BITS-1:0]        num_u;
  logic [NUMBER_BITS-1:0]        mag_in;
  logic [POW_W-1:0]              pow_k;
  logic                          ge;
  logic                          digit_emit;
  logic                          accept;

  assign num_ext = NUMBER_BITS'(in_item.number);
  assign num_u = num_ext;
  assign mag_in = num_ext[NUMBER_BITS-1] ? (~num_u + NUMBER_BITS'(1)) : num_u;
  assign pow_k = pow10(4'(k));
  assign ge = POW_W'(mag) >= pow_k;
  assign digit_emit = started || (cnt != 4'd0) || (k == KW'(0));

  assign in_stall = (state != F_IDLE) || q_stat.full;
  assign accept = in_valid && !in_stall;
  assign idle = (state == F_IDLE);

  always_comb begin
    state_next = state;
    pos_next = pos;
    neg_next = neg;
    mag_next = mag;
    k_next = k;
    cnt_next = cnt;
    started_next = started;
    push = 1'b0;
    push_op = '{kind: OP_CMD, value: 8'h00, last: 1'b0};
    case (state)
      F_IDLE: begin
        if (accept) begin
          case (in_item.action)
            ACT_CMD: begin
              push = 1'b1;
              push_op = '{kind: OP_CMD, value: in_item.byte_value, last: 1'b1};
            end
            ACT_DATA: begin
              push = 1'b1;
              push_op = '{kind: OP_DATA, value: in_item.byte_value, last: 1'b1};
            end
            ACT_NUM: begin
              pos_next = in_item.position;
              neg_next = num_ext[NUMBER_BITS-1];
              mag_next = mag_in;
              state_next = F_POS;
            end
            default: begin
              push = 1'b1;
              push_op = '{kind: OP_NIB, value: in_item.byte_value, last: 1'b1};
            end
          endcase
        end
      end
      F_POS: begin
        if (!q_stat.full) begin
          push = 1'b1;
          push_op = '{kind: OP_CMD, value: pos, last: 1'b0};
          k_next = KW'(DIGITS - 1);
          cnt_next = 4'd0;
          started_next = 1'b0;
          state_next = F_SIGN;
        end
      end
      F_SIGN: begin
        if (mag == '0) begin
          if (!q_stat.full) begin
            push = 1'b1;
            push_op = '{kind: OP_DATA, value: CHAR_ZERO, last: 1'b1};
            state_next = F_IDLE;
          end
        end else if (neg) begin
          if (!q_stat.full) begin
            push = 1'b1;
            push_op = '{kind: OP_DATA, value: CHAR_MINUS, last: 1'b0};
            state_next = F_DIGIT;
          end
        end else begin
          state_next = F_DIGIT;
        end
      end
      F_DIGIT: begin
        if (ge) begin
          mag_next = mag - NUMBER_BITS'(pow_k);
          cnt_next = cnt + 4'd1;
        end else if (!(digit_emit && q_stat.full)) begin
          if (digit_emit) begin
            push = 1'b1;
            push_op = '{kind: OP_DATA, value: CHAR_ZERO | {4'd0, cnt}, last: (k == KW'(0))};
          end
          started_next = started || digit_emit;
          cnt_next = 4'd0;
          if (k == KW'(0)) begin
            state_next = F_IDLE;
          end else begin
            k_next = k - KW'(1);
          end
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
    pos <= pos_next;
    neg <= neg_next;
    mag <= mag_next;
    k <= k_next;
    cnt <= cnt_next;
    started <= started_next;
  end

endmodule

/* sv/cles_queue.sv */
`timescale 1ns / 1ps
// Short operation queue between the front end and the back end.
// Depends on cles_pkg for the operation and status types.
module cles_queue
  import cles_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     pop_op,
  output q_stat_t q_stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  op_t           mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign q_stat.full = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop = pop && !q_stat.empty;
  assign pop_op = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* sv/cles_back.sv */
`timescale 1ns / 1ps
// Back end: plays each queued operation out as expander writes and keeps the port image.
// Depends on cles_pkg.
module cles_back
  import cles_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  op_t        q_op,
  input  q_stat_t    q_stat,
  output logic       pop,
  input  logic [7:0] address,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       out_stall
);

  logic       busy;
  op_t        op;
  logic [2:0] step;
  logic [7:0] image;

  logic [7:0] img_next;
  logic [2:0] last_step;
  logic [1:0] phase;
  logic [3:0] nib;
  logic       free;

  function automatic logic [7:0] apply_nib(input logic [7:0] img, input logic [3:0] n);
    logic [7:0] r;
    logic [7:0] line;
    r = img;
    for (int b = 0; b < 4; b++) begin
      line = 8'h10 << b;
      if (n[b]) begin
        r = r | line | BIT_BL;
      end else begin
        r = r & ~line;
      end
    end
    return r;
  endfunction

  assign free = !out_valid || !out_stall;
  assign pop = !busy && !q_stat.empty;

  always_comb begin
    last_step = (op.kind == OP_NIB) ? 3'd2 : 3'd7;
    if (op.kind == OP_NIB) begin
      phase = step[1:0];
      nib = op.value[3:0];
    end else if (step <= 3'd3) begin
      phase = 2'(step - 3'd1);
      nib = op.value[7:4];
    end else begin
      phase = 2'(step - 3'd4);
      nib = op.value[3:0];
    end
    if (op.kind != OP_NIB && step == 3'd0) begin
      img_next = (op.kind == OP_DATA) ? (image | BIT_RS | BIT_BL) : (image & ~BIT_RS);
    end else if (op.kind != OP_NIB && step == 3'd7) begin
      img_next = image & ~BIT_RS;
    end else begin
      case (phase)
        2'd0: img_next = apply_nib(image, nib);
        2'd1: img_next = image | BIT_E;
        default: img_next = image & ~BIT_E;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      image <= IMAGE_RESET;
      step <= 3'd0;
    end else begin
      if (busy && free) begin
        out_valid <= 1'b1;
        out_item <= '{bus_address: address, port_byte: img_next,
                      last: (step == last_step) && op.last};
        image <= img_next;
        if (step == last_step) begin
          busy <= 1'b0;
        end else begin
          step <= step + 3'd1;
        end
      end else if (free) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        op <= q_op;
        step <= 3'd0;
        busy <= 1'b1;
      end
    end
  end

endmodule

/* sv/char_lcd_expander_sequencer_core.sv */
`timescale 1ns / 1ps
// Character LCD sequencer over an 8-bit I2C port expander, 4-bit display mode.
// Input items (in_item) arrive on in_valid/in_stall; each one is a command byte, a data
// byte, a raw nibble, or a signed number shown at a cursor position. Expander writes
// leave on out_valid/out_stall as out_item, one per cycle at most; last marks the
// final write caused by an input item. cfg_wr_en/cfg_wr_data set the bus address.
// A raw nibble gives 3 writes, a byte 8 writes, a number 8 writes per character
// (cursor command, optional sign, up to five digits), so at most 56 writes for 16 bits.
// The back end sets the rate: one write per cycle while out_stall is low, with a gap
// while it loads each operation from the queue. An accepted item is pushed into the queue,
// popped into the back end's op register, then registered onto out_item; a number item
// first passes the front end's F_POS state. The front end finds each digit by repeated
// subtraction and runs ahead of the back end through a short operation queue.
// A stalled output holds its write; the queue then fills and in_stall rises.
// A number item holds in_stall high while its digits are produced.
// Synchronous reset empties the queue, clears out_valid and the back end's busy flag,
// sets the port image to backlight on and the bus address to 78.
// Depends on cles_pkg, cles_front, cles_queue and cles_back.
module char_lcd_expander_sequencer_core
  import cles_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  in_item_t   in_item,
  output logic       in_stall,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       out_stall,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] expander_address;
  logic       push;
  op_t        push_op;
  logic       pop;
  op_t        pop_op;
  q_stat_t    q_stat;
  logic       front_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      expander_address <= ADDR_RESET;
    end else if (cfg_wr_en) begin
      expander_address <= cfg_wr_data;
    end
  end

  cles_front #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_item (in_item),
    .in_stall(in_stall),
    .push    (push),
    .push_op (push_op),
    .q_stat  (q_stat),
    .idle    (front_idle)
  );

  cles_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .pop_op (pop_op),
    .q_stat (q_stat)
  );

  cles_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_op     (pop_op),
    .q_stat   (q_stat),
    .pop      (pop),
    .address  (expander_address),
    .out_valid(out_valid),
    .out_item (out_item),
    .out_stall(out_stall)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("operation pushed into a full queue");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> front_idle)
    else $error("item accepted while the front end is busy");

  a_backlight_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.port_byte[3])
    else $error("backlight bit cleared in an expander write");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
